FILE: rtl/psu_pkg.sv
// Shared types, codes and constants for the PNG scanline unfilter.
package psu_pkg;

    // Line store geometry
    localparam int unsigned STORE_DEPTH = 16384;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

    // Limits
    localparam int unsigned MAX_WIDTH_DEF = 4096;
    localparam int unsigned MAX_HEIGHT    = 65535;

    // Column counter width, wraps like the stream counter
    localparam int unsigned COL_W = 15;

    // Queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    // Row filter codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [2:0] FILT_BAD   = 3'd5;

    // Configuration registers
    typedef struct packed {
        logic [12:0] image_width;
        logic [15:0] image_height;
        logic        pixel_mode;
    } cfg_t;

    // One classified sample on its way to the back end
    typedef struct packed {
        logic [7:0]          data;
        logic [2:0]          filt;
        logic [STORE_AW-1:0] col;
        logic                first_row;
        logic                new_row;
        logic                row_end;
        logic                image_end;
    } entry_t;

endpackage

FILE: rtl/psu_front.sv
// Front end: takes stream bytes, tracks rows and columns, classifies samples.
module psu_front #(
    parameter int unsigned MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  psu_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             image_start,
    input  logic             q_full,
    output logic             q_push,
    output psu_pkg::entry_t  q_entry
);
    import psu_pkg::*;

    localparam int unsigned RBW = $clog2(4 * MAX_WIDTH + 1);

    logic [COL_W-1:0] byte_column_reg, byte_column_next;
    logic [15:0]      row_count_reg, row_count_next;
    logic [2:0]       row_filter_reg, row_filter_next;
    logic             first_row_reg, first_row_next;
    logic             expect_reg, expect_next;
    logic             new_row_reg, new_row_next;

    logic             accept;
    logic             expect_eff;
    logic             first_eff;
    logic [15:0]      row_count_eff;
    logic [COL_W-1:0] col_eff;
    logic [COL_W-1:0] col_inc;
    logic [RBW-1:0]   width_eff;
    logic [RBW-1:0]   row_bytes;
    logic [15:0]      height_eff;
    logic             row_done;
    logic             last_row;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Clamped geometry
    always_comb
    begin
        if (cfg.image_width == '0)
            width_eff = RBW'(1);
        else if ({19'd0, cfg.image_width} > 32'(MAX_WIDTH))
            width_eff = RBW'(MAX_WIDTH);
        else
            width_eff = RBW'(cfg.image_width);

        if (cfg.image_height == '0)
            height_eff = 16'd1;
        else if ({16'd0, cfg.image_height} > 32'(MAX_HEIGHT))
            height_eff = 16'(MAX_HEIGHT);
        else
            height_eff = cfg.image_height;
    end

    assign row_bytes = cfg.pixel_mode ? (width_eff << 2) : (width_eff + (width_eff << 1));

    // Image start restarts counting before the byte is classified
    assign expect_eff    = image_start || expect_reg;
    assign first_eff     = image_start || first_row_reg;
    assign row_count_eff = image_start ? 16'd0 : row_count_reg;
    assign col_eff       = image_start ? '0 : byte_column_reg;
    assign col_inc       = col_eff + COL_W'(1);
    assign row_done      = 32'(col_inc) >= 32'(row_bytes);
    assign last_row      = ({1'b0, row_count_eff} + 17'd1) >= {1'b0, height_eff};

    // Queue entry for a sample byte
    assign q_push            = accept && !expect_eff;
    assign q_entry.data      = data_byte;
    assign q_entry.filt      = row_filter_reg;
    assign q_entry.col       = col_eff[STORE_AW-1:0];
    assign q_entry.first_row = first_eff;
    assign q_entry.new_row   = new_row_reg;
    assign q_entry.row_end   = row_done;
    assign q_entry.image_end = row_done && last_row;

    // Row and column tracking
    always_comb
    begin
        byte_column_next = byte_column_reg;
        row_count_next   = row_count_reg;
        row_filter_next  = row_filter_reg;
        first_row_next   = first_row_reg;
        expect_next      = expect_reg;
        new_row_next     = new_row_reg;
        if (accept)
        begin
            if (expect_eff)
            begin
                row_filter_next  = (data_byte > {5'd0, FILT_PAETH}) ? FILT_BAD
                                                                    : data_byte[2:0];
                byte_column_next = '0;
                row_count_next   = row_count_eff;
                first_row_next   = first_eff;
                expect_next      = 1'b0;
                new_row_next     = 1'b1;
            end
            else
            begin
                new_row_next     = 1'b0;
                byte_column_next = col_inc;
                row_count_next   = row_count_eff;
                first_row_next   = first_eff;
                if (row_done)
                begin
                    byte_column_next = '0;
                    expect_next      = 1'b1;
                    if (last_row)
                    begin
                        row_count_next = 16'd0;
                        first_row_next = 1'b1;
                    end
                    else
                    begin
                        row_count_next = row_count_eff + 16'd1;
                        first_row_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= '0;
            row_count_reg   <= '0;
            row_filter_reg  <= FILT_NONE;
            first_row_reg   <= 1'b1;
            expect_reg      <= 1'b1;
            new_row_reg     <= 1'b1;
        end
        else
        begin
            byte_column_reg <= byte_column_next;
            row_count_reg   <= row_count_next;
            row_filter_reg  <= row_filter_next;
            first_row_reg   <= first_row_next;
            expect_reg      <= expect_next;
            new_row_reg     <= new_row_next;
        end
    end

`ifndef SYNTHESIS
    // A pushed entry always stems from an accepted sample byte
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (in_valid && in_ready && !expect_eff))
        else $error("front pushed without an accepted sample");

    // The first sample after a filter byte is marked as a row start
    a_new_row_after_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && expect_eff) |=> new_row_reg && !expect_reg)
        else $error("filter byte did not open a row");
`endif

endmodule

FILE: rtl/psu_queue.sv
// Short queue of classified samples between front and back end.
module psu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  psu_pkg::entry_t  push_entry,
    input  logic             pop,
    output psu_pkg::entry_t  head,
    output logic             head_valid,
    output logic             full
);
    import psu_pkg::*;

    entry_t              slots [QDEPTH];
    logic [QAW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]        count_reg, count_next;

    assign head       = slots[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == (QAW+1)'(QDEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QAW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QAW+1)'(1);
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underflow");
`endif

endmodule

FILE: rtl/psu_back.sv
// Back end: line store, neighbor registers, filter reconstruction, output register.
module psu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  psu_pkg::cfg_t    cfg,
    input  psu_pkg::entry_t  head,
    input  logic             head_valid,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       pixel_byte,
    output logic             row_end,
    output logic             image_end,
    output logic             bad_filter
);
    import psu_pkg::*;

    // Paeth predictor, ties to a then b
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [8:0] sab;
        logic [8:0] scc;
        logic [8:0] pc;
        pa  = (b > c) ? b - c : c - b;
        pb  = (a > c) ? a - c : c - a;
        sab = {1'b0, a} + {1'b0, b};
        scc = {c, 1'b0};
        pc  = (sab > scc) ? sab - scc : scc - sab;
        if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc))
            return a;
        else if ({1'b0, pb} <= pc)
            return b;
        else
            return c;
    endfunction

    logic [7:0]  row_store [STORE_DEPTH];
    logic [7:0]  up_byte_reg;
    entry_t      s1_reg;
    logic        s1_valid_reg;
    logic [31:0] left_reg;
    logic [31:0] upleft_reg;
    logic        out_valid_reg;
    logic [7:0]  pixel_byte_reg;
    logic        row_end_reg, image_end_reg, bad_filter_reg;

    logic        s1_adv;
    logic [31:0] left_eff;
    logic [31:0] upleft_eff;
    logic [7:0]  a, b, c;
    logic [8:0]  avg_sum;
    logic [7:0]  res;
    logic        bad;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop    = head_valid && (!s1_valid_reg || s1_adv);

    // Neighbor bytes, zero at the start of a row and above the first row
    assign left_eff   = s1_reg.new_row ? 32'd0 : left_reg;
    assign upleft_eff = s1_reg.new_row ? 32'd0 : upleft_reg;
    assign a          = cfg.pixel_mode ? left_eff[31:24] : left_eff[23:16];
    assign c          = cfg.pixel_mode ? upleft_eff[31:24] : upleft_eff[23:16];
    assign b          = s1_reg.first_row ? 8'd0 : up_byte_reg;
    assign avg_sum    = {1'b0, a} + {1'b0, b};

    // Reconstruction
    always_comb
    begin
        bad = 1'b0;
        case (s1_reg.filt)
            FILT_NONE:  res = s1_reg.data;
            FILT_SUB:   res = s1_reg.data + a;
            FILT_UP:    res = s1_reg.data + b;
            FILT_AVG:   res = s1_reg.data + avg_sum[8:1];
            FILT_PAETH: res = s1_reg.data + paeth_pick(a, b, c);
            default:
            begin
                res = s1_reg.data;
                bad = 1'b1;
            end
        endcase
    end

    // Line store: read on pop, write when the sample retires
    always_ff @(posedge clk)
    begin
        if (pop)
            up_byte_reg <= row_store[head.col];
        if (s1_adv)
            row_store[s1_reg.col] <= res;
    end

    // Stage payload and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= head;
        if (s1_adv)
        begin
            pixel_byte_reg <= res;
            row_end_reg    <= s1_reg.row_end;
            image_end_reg  <= s1_reg.image_end;
            bad_filter_reg <= bad;
        end
    end

    // Control and pixel history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            upleft_reg    <= '0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                left_reg   <= {left_eff[23:0], res};
                upleft_reg <= {upleft_eff[23:0], b};
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_byte_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;
    assign bad_filter = bad_filter_reg;

`ifndef SYNTHESIS
    // The image end always closes a row
    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_end) |-> row_end)
        else $error("image end without row end");

    // A sample only moves on into a free or draining output register
    a_no_output_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(pixel_byte))
        else $error("pending transaction lost");
`endif

endmodule

FILE: rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: configuration registers and hookup.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_ready    data_byte, image_start
//  output    out        out_valid / out_ready  pixel_byte, row_end, image_end, bad_filter
//  config    in         cfg_write              cfg_index, cfg_data
//
// One byte is taken per cycle while the queue is not full, filter bytes and sample
// bytes alike; a sample's transaction passes the queue, the reconstruction stage
// with the line store read, then the output register, and can stall in each.
// The Paeth select and add in the reconstruction stage is the longest path; the
// line store read is registered beside the reconstruction stage payload.
// Reset clears all control state at once; the line store has no clearing pass and
// the first row of an image reads zero above.
// With out_ready low the output register, the reconstruction stage and the two-entry
// queue fill in turn, then in_ready drops.
module png_scanline_unfilter #(
    parameter int unsigned MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               image_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         pixel_byte,
    output logic                               row_end,
    output logic                               image_end,
    output logic                               bad_filter
);
    import psu_pkg::*;

    cfg_t   cfg_reg;
    entry_t q_entry;
    entry_t q_head;
    logic   q_push;
    logic   q_pop;
    logic   q_head_valid;
    logic   q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.pixel_mode   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  cfg_reg.image_width  <= cfg_data[12:0];
                CFG_IDX_HEIGHT: cfg_reg.image_height <= cfg_data[15:0];
                CFG_IDX_MODE:   cfg_reg.pixel_mode   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    psu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .full       (q_full)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .row_end    (row_end),
        .image_end  (image_end),
        .bad_filter (bad_filter)
    );

endmodule

FILE: verif/png_scanline_unfilter_tb.sv
// Self-checking testbench for the PNG scanline unfilter: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
    import psu_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned IDLE_PCT    = 27;
    localparam int unsigned RAND_BYTES  = 1000;
    localparam int unsigned MAX_REPORTS = 50;
    localparam int unsigned WIDE_BYTES  = 200;

    // One byte of the inflated stream
    typedef struct {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    // One reconstructed sample as the block should present it
    typedef struct {
        logic [7:0] pixel;
        logic       last_in_row;
        logic       last_in_image;
        logic       bad_filt;
    } px_result_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte   = '0;
    logic                  image_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [7:0]            pixel_byte;
    logic                  row_end;
    logic                  image_end;
    logic                  bad_filter;

    // Stimulus and expectation stores
    stream_byte_t stream_bytes[$];
    px_result_t   pixels_due[$];
    stream_byte_t next_byte;
    px_result_t   due_px;
    bit           holding      = 1'b0;
    bit           calm         = 1'b0;
    int unsigned  bytes_queued = 0;
    int unsigned  err_count    = 0;
    int unsigned  quiet_cycles = 0;

    // Configuration mirror
    logic [12:0] cfg_width  = 13'd1;
    logic [15:0] cfg_height = 16'd1;
    logic        cfg_mode   = 1'b0;

    // Unfilter state
    bit   [7:0]  line_mem [STORE_DEPTH];
    logic [31:0] left_px     = '0;
    logic [31:0] upleft_px   = '0;
    logic [14:0] col_cnt     = '0;
    logic [15:0] row_cnt     = '0;
    logic [2:0]  row_filt    = FILT_NONE;
    logic        first_row   = 1'b1;
    logic        want_filter = 1'b1;

    png_scanline_unfilter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .image_end   (image_end),
        .bad_filter  (bad_filter)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Effective geometry after clamping
    function automatic int unsigned eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic int unsigned row_bytes();
        return eff_width() * (cfg_mode ? 4 : 3);
    endfunction

    // Paeth: nearest of left, above, upper-left to left + above - upper-left
    function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        int da;
        int db;
        int dc;
        int sum_ab;
        int twice_c;
        sum_ab  = a + b;
        twice_c = 2 * c;
        da = (b > c) ? b - c : c - b;
        db = (a > c) ? a - c : c - a;
        dc = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    task automatic restart_image();
        row_cnt     = '0;
        col_cnt     = '0;
        first_row   = 1'b1;
        want_filter = 1'b1;
        left_px     = '0;
        upleft_px   = '0;
    endtask

    // Predict the block's reaction to one accepted stream byte
    task automatic unfilter_byte(input logic [7:0] d, input logic st);
        int unsigned bpp;
        int unsigned rb;
        logic [STORE_AW-1:0] col;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] res;
        logic [8:0] pair;
        px_result_t r;
        if (st)
            restart_image();
        if (want_filter)
        begin
            row_filt    = (d > FILT_PAETH) ? FILT_BAD : d[2:0];
            col_cnt     = '0;
            left_px     = '0;
            upleft_px   = '0;
            want_filter = 1'b0;
        end
        else
        begin
            bpp  = cfg_mode ? 4 : 3;
            rb   = row_bytes();
            col  = col_cnt[STORE_AW-1:0];
            a    = left_px[8*(bpp-1) +: 8];
            c    = upleft_px[8*(bpp-1) +: 8];
            b    = first_row ? 8'h00 : line_mem[col];
            pair = a + b;
            r.bad_filt = 1'b0;
            case (row_filt)
                FILT_NONE:  res = d;
                FILT_SUB:   res = d + a;
                FILT_UP:    res = d + b;
                FILT_AVG:   res = d + pair[8:1];
                FILT_PAETH: res = d + paeth_choice(a, b, c);
                default:
                begin
                    res        = d;
                    r.bad_filt = 1'b1;
                end
            endcase
            line_mem[col] = res;
            left_px       = {left_px[23:0], res};
            upleft_px     = {upleft_px[23:0], b};
            col_cnt       = col_cnt + 1'b1;
            r.pixel         = res;
            r.last_in_row   = 1'b0;
            r.last_in_image = 1'b0;
            if (col_cnt >= rb)
            begin
                r.last_in_row = 1'b1;
                if (row_cnt + 1 >= eff_height())
                begin
                    r.last_in_image = 1'b1;
                    restart_image();
                end
                else
                begin
                    row_cnt     = row_cnt + 1'b1;
                    first_row   = 1'b0;
                    want_filter = 1'b1;
                    col_cnt     = '0;
                end
            end
            pixels_due.insert(pixels_due.size(), r);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // Driver: feeds queued stream bytes, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            data_byte   <= '0;
            image_start <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                unfilter_byte(data_byte, image_start);
                holding = 1'b0;
            end
            if (!in_valid || in_ready)
            begin
                if (stream_bytes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_byte = stream_bytes.pop_front();
                    holding   = 1'b1;
                    in_valid    <= 1'b1;
                    data_byte   <= next_byte.data;
                    image_start <= next_byte.start;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transaction against the oldest predicted sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    report_mismatch($sformatf("transaction with nothing due, pixel_byte %02h",
                                              pixel_byte));
                end
                else
                begin
                    due_px = pixels_due.pop_front();
                    if (pixel_byte !== due_px.pixel)
                        report_mismatch($sformatf("pixel_byte %02h, want %02h",
                                                  pixel_byte, due_px.pixel));
                    if (row_end !== due_px.last_in_row)
                        report_mismatch($sformatf("row_end %b, want %b",
                                                  row_end, due_px.last_in_row));
                    if (image_end !== due_px.last_in_image)
                        report_mismatch($sformatf("image_end %b, want %b",
                                                  image_end, due_px.last_in_image));
                    if (bad_filter !== due_px.bad_filt)
                        report_mismatch($sformatf("bad_filter %b, want %b",
                                                  bad_filter, due_px.bad_filt));
                end
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic st);
        stream_byte_t sb;
        sb.data  = d;
        sb.start = st;
        stream_bytes.insert(stream_bytes.size(), sb);
        bytes_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (stream_bytes.size() != 0 || holding || pixels_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write; leaves cfg_write high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        case (idx)
            CFG_IDX_WIDTH:  cfg_width  = val[12:0];
            CFG_IDX_HEIGHT: cfg_height = val[15:0];
            CFG_IDX_MODE:   cfg_mode   = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned m);
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        write_reg(CFG_IDX_MODE, m);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(99) < 10)
            return 8'($urandom_range(255, FILT_BAD));
        return 8'($urandom_range(FILT_PAETH, FILT_NONE));
    endfunction

    // Whole image with random filters and samples, optionally cut short
    task automatic queue_image(input int unsigned rows, input int unsigned rb, input bit cut);
        int unsigned total;
        int unsigned stop_at;
        int unsigned n;
        total   = rows * (rb + 1);
        stop_at = cut ? $urandom_range(total - 1, 1) : total;
        n       = 0;
        for (int unsigned r = 0; r < rows && n < stop_at; r++)
        begin
            push_byte(pick_filter(), r == 0);
            n++;
            for (int unsigned k = 0; k < rb && n < stop_at; k++)
            begin
                push_byte(8'($urandom_range(255)), 1'b0);
                n++;
            end
        end
    endtask

    initial
    begin
        int unsigned base;
        int unsigned phase;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned rows;
        int unsigned n_img;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero width and height clamp to one pixel, one row; Paeth on an empty
        // neighborhood, then a bad filter on the image that starts by itself
        set_config(0, 0, 0);
        push_byte(8'(FILT_PAETH), 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hAA, 1'b0);
        wait_idle();

        // Sub then Average with real neighbors
        set_config(2, 2, 0);
        push_byte(8'(FILT_SUB), 1'b1);
        repeat (6) push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'(FILT_AVG), 1'b0);
        repeat (6) push_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();

        // Narrow width and drop to RGB in the middle of a row; Up reads it back
        set_config(2, 2, 1);
        push_byte(8'(FILT_NONE), 1'b1);
        repeat (3) push_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();
        write_reg(CFG_IDX_WIDTH, 1);
        write_reg(CFG_IDX_MODE, 0);
        cfg_write <= 1'b0;
        push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'(FILT_UP), 1'b0);
        repeat (3) push_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();

        // Random phases of small images
        base  = bytes_queued;
        phase = 0;
        while (bytes_queued - base < RAND_BYTES)
        begin
            sel = $urandom_range(99);
            w   = (sel < 10) ? 0 : ((sel < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7));
            sel = $urandom_range(99);
            h   = (sel < 10) ? 0 : ((sel < 80) ? $urandom_range(4, 1) : $urandom_range(12, 5));
            if (phase == 1)
                h = 65535;
            n_img = $urandom_range(3, 1);
            calm  = (phase == 2);
            if (calm)
            begin
                w     = 6;
                h     = 8;
                n_img = 3;
            end
            set_config(w, h, $urandom_range(1));
            rows = (eff_height() > 12) ? 12 : eff_height();
            repeat (n_img) queue_image(rows, row_bytes(), !calm && $urandom_range(99) < 15);
            // occasional stray bytes, now and then with a restart among them
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(8, 1))
                    push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            wait_idle();
            calm = 1'b0;
            phase++;
        end

        // Widest setting: width above the limit clamps, RGBA, the head of a long first row
        set_config(8191, 2, 1);
        push_byte(8'(FILT_PAETH), 1'b1);
        repeat (WIDE_BYTES) push_byte(8'($urandom_range(255)), 1'b0);
        wait_idle();

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
